// File: rtl/wrp_pkg.sv
package wrp_pkg;

  // Configured bound on the job count and the most ranges one result stream can carry.
  localparam int MAX_RANGES = 16;
  localparam int RESULT_CAP = 16;
  localparam int JOB_CAP    = (MAX_RANGES < RESULT_CAP) ? MAX_RANGES : RESULT_CAP;

  // Field widths.
  localparam int CNT_W  = 31;
  localparam int DIV_W  = 32;
  localparam int JOBS_W = 5;
  localparam int IDX_W  = 4;
  localparam int WRK_W  = 6;

  // Quotient bits resolved by one divider stage, and the stage count.
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_BITS;

  // Register byte addresses.
  localparam logic [1:0] ADDR_WORKER_THREADS = 2'd0;

  // One entry of the divider pipeline.
  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  t;
    logic [JOBS_W-1:0] d;
    logic [DIV_W-1:0]  work;
    logic [3:0]        rem;
  } div_t;

  // One finished partition waiting for the emitter.
  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  t;
    logic [CNT_W-1:0]  size;
    logic [JOBS_W-1:0] revised;
  } part_t;

  // Counts k in 1..RESULT_CAP with k <= lim and (k-1)*mult < t; k = 1 always counts.
  // This equals min(lim, ceil(t / mult)) for mult >= 1 and t >= 1.
  function automatic logic [JOBS_W-1:0] count_below(input logic [CNT_W-1:0] t,
                                                    input logic [CNT_W-1:0] mult,
                                                    input logic [JOBS_W-1:0] lim);
    logic [CNT_W+4:0]      prod;
    logic [RESULT_CAP-1:0] hit;
    hit = '0;
    for (int k = 1; k <= RESULT_CAP; k++) begin
      prod = (CNT_W+5)'(mult) * (CNT_W+5)'(k - 1);
      hit[k-1] = ((k == 1) || (prod < (CNT_W+5)'(t))) && (JOBS_W'(k) <= lim);
    end
    return JOBS_W'($countones(hit));
  endfunction

endpackage

// File: rtl/wrp_div_stage.sv
module wrp_div_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  wrp_pkg::div_t stage_i,
  output wrp_pkg::div_t stage_o
);
  import wrp_pkg::*;

  div_t       stage_r;
  div_t       stage_nxt;
  logic [4:0] part;

  // Restoring division, several quotient bits per stage. Quotient bits shift
  // into the low end of the work word as dividend bits leave the top.
  always_comb begin
    stage_nxt = stage_i;
    part      = '0;
    for (int s = 0; s < DIV_BITS; s++) begin
      part           = {stage_nxt.rem, stage_nxt.work[DIV_W-1]};
      stage_nxt.work = {stage_nxt.work[DIV_W-2:0], 1'b0};
      if (part >= stage_nxt.d) begin
        part              = part - stage_nxt.d;
        stage_nxt.work[0] = 1'b1;
      end
      stage_nxt.rem = part[3:0];
    end
  end

  // Stage register; the valid bit is the only control state and the only
  // field that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

// File: rtl/wrp_emit.sv
module wrp_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wrp_pkg::part_t              part_i,
  output logic                        take_o,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wrp_pkg::CNT_W-1:0]   out_range_start,
  output logic [wrp_pkg::CNT_W-1:0]   out_range_size,
  output logic [wrp_pkg::IDX_W-1:0]   out_range_index,
  output logic [wrp_pkg::JOBS_W-1:0]  out_ranges_total,
  output logic                        out_last_range
);
  import wrp_pkg::*;

  logic              valid_r;
  logic [CNT_W-1:0]  start_r;
  logic [CNT_W-1:0]  len_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  size_r;
  logic [IDX_W-1:0]  idx_r;
  logic [JOBS_W-1:0] tot_r;
  logic              last_r;

  logic              step;
  logic [CNT_W-1:0]  rem_nxt;
  logic              last_nxt;
  logic              first_last;

  // A new partition loads when the output is empty or its final range leaves.
  assign take_o = !valid_r || (out_ready && last_r);
  assign step   = valid_r && out_ready && !last_r;

  assign rem_nxt    = rem_r - size_r;
  assign last_nxt   = ({1'b0, idx_r} + JOBS_W'(2)) == tot_r;
  assign first_last = part_i.revised == JOBS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_o) begin
      valid_r <= part_i.vld;
    end
  end

  // Output fields; the remainder register gives the final range's length.
  always_ff @(posedge clk) begin
    if (take_o) begin
      start_r <= '0;
      rem_r   <= part_i.t;
      size_r  <= part_i.size;
      len_r   <= first_last ? part_i.t : part_i.size;
      idx_r   <= '0;
      tot_r   <= part_i.revised;
      last_r  <= first_last;
    end else if (step) begin
      start_r <= start_r + size_r;
      rem_r   <= rem_nxt;
      len_r   <= last_nxt ? rem_nxt : size_r;
      idx_r   <= idx_r + IDX_W'(1);
      last_r  <= last_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_range_start  = start_r;
  assign out_range_size   = len_r;
  assign out_range_index  = idx_r;
  assign out_ranges_total = tot_r;
  assign out_last_range   = last_r;

endmodule

// File: rtl/work_range_partitioner_core.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_total_count, in_min_per_range
// out_      output     out_valid/out_ready  out_range_start, out_range_size,
//                                           out_range_index, out_ranges_total,
//                                           out_last_range
// cfg (APB) input      psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// A request passes an input stage, a job-count stage, eight divider stages of
// four quotient bits each, a range-count stage and the emitter register, in that
// order. The emitter then gives one range per cycle while out_ready is high, so
// the output port sets the sustained rate. Reset clears all valid bits and
// worker_threads at once. While the range-count stage holds a partition that the
// emitter cannot take yet, the whole pipeline holds.
module work_range_partitioner_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wrp_pkg::CNT_W-1:0]   in_total_count,
  input  logic [wrp_pkg::CNT_W-1:0]   in_min_per_range,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wrp_pkg::CNT_W-1:0]   out_range_start,
  output logic [wrp_pkg::CNT_W-1:0]   out_range_size,
  output logic [wrp_pkg::IDX_W-1:0]   out_range_index,
  output logic [wrp_pkg::JOBS_W-1:0]  out_ranges_total,
  output logic                        out_last_range,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import wrp_pkg::*;

  logic [WRK_W-1:0]  worker_r;
  logic [7:0]        cap_wide;
  logic [JOBS_W-1:0] cap;

  logic              adv;
  logic              take;

  logic              s0_vld_r;
  logic [CNT_W-1:0]  s0_t_r;
  logic [CNT_W-1:0]  s0_m_r;
  logic              s1_vld_r;
  logic [CNT_W-1:0]  s1_t_r;
  logic [JOBS_W-1:0] s1_jobs_r;

  div_t              div_in   [DIV_STAGES];
  div_t              div_out  [DIV_STAGES];
  div_t              div_tail;
  part_t             part_r;

  // Configuration register; writes complete in the APB access phase.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_WORKER_THREADS) ? {{(32-WRK_W){1'b0}}, worker_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_WORKER_THREADS)) begin
      worker_r <= pwdata[WRK_W-1:0];
    end
  end

  // Upper bound on the job count from the worker count.
  assign cap_wide = 8'({worker_r, 1'b0}) + 8'd2;
  always_comb begin
    if (worker_r == '0) begin
      cap = JOBS_W'(1);
    end else if (cap_wide < 8'(JOB_CAP)) begin
      cap = cap_wide[JOBS_W-1:0];
    end else begin
      cap = JOBS_W'(JOB_CAP);
    end
  end

  // The whole pipeline moves whenever the emitter can take the tail entry.
  assign adv      = !part_r.vld || take;
  assign in_ready = adv;

  // Input and job-count stages; a zero minimum counts as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_t_r    <= in_total_count;
      s0_m_r    <= (in_min_per_range == '0) ? CNT_W'(1) : in_min_per_range;
      s1_t_r    <= s0_t_r;
      s1_jobs_r <= count_below(s0_t_r, s0_m_r, cap);
    end
  end

  // Divider chain for ceil(total / jobs).
  always_comb begin
    div_in[0].vld  = s1_vld_r;
    div_in[0].t    = s1_t_r;
    div_in[0].d    = s1_jobs_r;
    div_in[0].work = {1'b0, s1_t_r} + DIV_W'(s1_jobs_r) - DIV_W'(1);
    div_in[0].rem  = '0;
    for (int i = 1; i < DIV_STAGES; i++) begin
      div_in[i] = div_out[i-1];
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    wrp_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stage_i (div_in[g]),
      .stage_o (div_out[g])
    );
  end

  assign div_tail = div_out[DIV_STAGES-1];

  // Range-count stage: revised count is ceil(total / size).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r.vld <= 1'b0;
    end else if (adv) begin
      part_r.vld     <= div_tail.vld;
      part_r.t       <= div_tail.t;
      part_r.size    <= div_tail.work[CNT_W-1:0];
      part_r.revised <= count_below(div_tail.t, div_tail.work[CNT_W-1:0],
                                    JOBS_W'(RESULT_CAP));
    end
  end

  wrp_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .part_i           (part_r),
    .take_o           (take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_range_start  (out_range_start),
    .out_range_size   (out_range_size),
    .out_range_index  (out_range_index),
    .out_ranges_total (out_ranges_total),
    .out_last_range   (out_last_range)
  );

endmodule

// File: sim/work_range_partitioner_core_test.sv
`timescale 1ns / 100ps

module work_range_partitioner_core_test;
  import wrp_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // One expected range of a partition.
  typedef struct packed {
    logic [CNT_W-1:0]  rstart;
    logic [CNT_W-1:0]  rsize;
    logic [IDX_W-1:0]  ridx;
    logic [JOBS_W-1:0] rtotal;
    logic              rlast;
  } range_rec_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CNT_W-1:0]  in_total_count;
  logic [CNT_W-1:0]  in_min_per_range;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic [CNT_W-1:0]  out_range_start;
  logic [CNT_W-1:0]  out_range_size;
  logic [IDX_W-1:0]  out_range_index;
  logic [JOBS_W-1:0] out_ranges_total;
  logic              out_last_range;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [1:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  range_rec_t        pending_ranges[$];
  logic [WRK_W-1:0]  worker_cfg = '0;
  logic              in_gap_on = 1'b0;
  logic              out_stall_on = 1'b0;
  int                ready_run = 0;
  int                idle_cycles = 0;
  int                errors = 0;
  int                requests_sent = 0;
  int                ranges_seen = 0;
  int                settings_used = 0;

  work_range_partitioner_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_total_count   (in_total_count),
    .in_min_per_range (in_min_per_range),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_range_start  (out_range_start),
    .out_range_size   (out_range_size),
    .out_range_index  (out_range_index),
    .out_ranges_total (out_ranges_total),
    .out_last_range   (out_last_range),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      gap = 0;
    end else if (r < 85) begin
      gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 40);
    end
    return gap;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    errors++;
  endtask

  // Appends one expected range at the tail of the queue.
  function automatic void add_expected(input range_rec_t r);
    pending_ranges.insert(pending_ranges.size(), r);
  endfunction

  // Splits one request into its ranges and queues them as expected results.
  function automatic void plan_partition(input logic [CNT_W-1:0] total,
                                         input logic [CNT_W-1:0] minimum);
    logic [63:0] t;
    logic [63:0] m;
    logic [63:0] jobs;
    logic [63:0] chunk;
    logic [63:0] revised;
    logic [63:0] i;
    range_rec_t  r;
    t = 64'(total);
    m = (minimum == '0) ? 64'd1 : 64'(minimum);
    if (t == 0) begin
      r.rstart = '0;
      r.rsize  = '0;
      r.ridx   = '0;
      r.rtotal = JOBS_W'(1);
      r.rlast  = 1'b1;
      add_expected(r);
    end else begin
      if (worker_cfg == '0) begin
        jobs = 64'd1;
      end else begin
        jobs = (t + m - 1) / m;
        if (jobs > (64'(worker_cfg) + 1) * 2) jobs = (64'(worker_cfg) + 1) * 2;
        if (jobs > 64'(MAX_RANGES)) jobs = 64'(MAX_RANGES);
      end
      if (jobs > 64'(RESULT_CAP)) jobs = 64'(RESULT_CAP);
      chunk   = (t + jobs - 1) / jobs;
      revised = (t + chunk - 1) / chunk;
      for (i = 0; i < revised; i++) begin
        r.rlast  = (i == revised - 1);
        r.rstart = CNT_W'(chunk * i);
        r.rsize  = r.rlast ? CNT_W'(t - chunk * i) : CNT_W'(chunk);
        r.ridx   = IDX_W'(i);
        r.rtotal = JOBS_W'(revised);
        add_expected(r);
      end
    end
  endfunction

  // Sends one request after an optional gap and queues its ranges on acceptance.
  task automatic send_request(input logic [CNT_W-1:0] total,
                              input logic [CNT_W-1:0] minimum);
    int gap;
    gap = in_gap_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_total_count   <= total;
    in_min_per_range <= minimum;
    do @(posedge clk); while (!in_ready);
    plan_partition(total, minimum);
    requests_sent++;
  endtask

  // Drops the input valid and waits until every expected range has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_ranges.size() != 0);
    @(posedge clk);
  endtask

  // Writes worker_threads over the register port and reads it back.
  task automatic write_workers(input logic [WRK_W-1:0] workers);
    logic [31:0] word;
    word = $urandom;
    word[WRK_W-1:0] = workers;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WORKER_THREADS;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    worker_cfg = workers;
    settings_used++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[WRK_W-1:0] !== workers) begin
      report_mismatch("worker_threads readback", 64'(workers), 64'(prdata[WRK_W-1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random request, weighted toward totals and minimums that give many ranges.
  task automatic send_random_request();
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] minimum;
    case ($urandom_range(0, 9))
      0: begin
        total = '0;
      end
      1: begin
        total = CNT_W'($urandom);
      end
      2: begin
        total = CNT_MAX - CNT_W'($urandom_range(0, 3));
      end
      default: begin
        total = CNT_W'($urandom_range(1, 300));
      end
    endcase
    case ($urandom_range(0, 7))
      0: begin
        minimum = '0;
      end
      1: begin
        minimum = CNT_W'($urandom);
      end
      2: begin
        minimum = total + CNT_W'($urandom_range(0, 2)) - CNT_W'(1);
      end
      3: begin
        minimum = CNT_MAX;
      end
      default: begin
        minimum = CNT_W'($urandom_range(1, 40));
      end
    endcase
    send_request(total, minimum);
  endtask

  // With no workers every nonzero request is a single range.
  task automatic test_single_job();
    send_request('0, '0);
    send_request(CNT_W'(1), '0);
    send_request(CNT_MAX, '0);
    send_request(CNT_MAX, CNT_MAX);
    send_request(CNT_W'(5), CNT_W'(3));
  endtask

  // Most workers: the range cap, uneven splits and shrinking range counts.
  task automatic test_full_spread();
    wait_drain();
    write_workers(WRK_W'(63));
    send_request(CNT_MAX, CNT_W'(1));
    send_request(CNT_W'(1), CNT_W'(1));
    send_request(CNT_W'(16), CNT_W'(1));
    send_request(CNT_W'(17), CNT_W'(1));
    send_request(CNT_W'(100), '0);
    send_request('0, CNT_MAX);
    send_request(CNT_MAX, CNT_MAX);
    send_request(CNT_W'(15), CNT_W'(1));
    send_request(CNT_W'(33), CNT_W'(2));
    send_request(CNT_W'(32'h4000_0000), CNT_W'(32'h3FFF_FFFF));
  endtask

  // A single worker limits a request to four ranges.
  task automatic test_worker_limit();
    wait_drain();
    write_workers(WRK_W'(1));
    in_gap_on    = 1'b1;
    out_stall_on = 1'b1;
    send_request(CNT_W'(100), CNT_W'(1));
    send_request(CNT_W'(7), CNT_W'(1));
    send_request(CNT_W'(5), CNT_W'(2));
    send_request('0, CNT_W'(5));
  endtask

  // Random requests under a series of worker settings and stall patterns.
  task automatic test_random_settings();
    logic [WRK_W-1:0] setting[6];
    int p;
    int n;
    setting = '{WRK_W'(1), WRK_W'(63), WRK_W'(0), WRK_W'(7), WRK_W'(2), WRK_W'($urandom)};
    for (p = 0; p < 6; p++) begin
      wait_drain();
      write_workers(setting[p]);
      in_gap_on    = (p != 0);
      out_stall_on = (p != 0);
      for (n = 0; n < 62; n++) begin
        if (p > 1 && n % 16 == 0) begin
          in_gap_on    = 1'($urandom_range(0, 1));
          out_stall_on = $urandom_range(0, 3) != 0;
        end
        send_random_request();
      end
    end
  endtask

  // The sender holds off until the partitioner has emptied, then resumes.
  task automatic test_drain_pause();
    int n;
    in_gap_on    = 1'b1;
    out_stall_on = 1'b1;
    for (n = 0; n < 10; n++) send_random_request();
    wait_drain();
    for (n = 0; n < 10; n++) send_random_request();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_total_count   <= '0;
    in_min_per_range <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= ADDR_WORKER_THREADS;
    pwdata           <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_single_job();
    test_full_spread();
    test_worker_limit();
    test_random_settings();
    test_drain_pause();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d requests, %0d ranges checked, %0d worker settings written.",
             requests_sent, ranges_seen, settings_used);
    $display("Zero and full-width totals and minimums were mixed with stalls on both sides.");
    if (errors == 0) begin
      $display("PASS work_range_partitioner_core");
    end else begin
      $display("FAIL work_range_partitioner_core");
    end
    $finish;
  end

  // Result side ready: random stalls of varied length, or always ready.
  always @(posedge clk) begin
    if (!out_stall_on) begin
      out_ready <= 1'b1;
      ready_run <= 0;
    end else if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      ready_run <= pick_gap();
    end else begin
      out_ready <= 1'b1;
      ready_run <= $urandom_range(0, 5);
    end
  end

  // Compare every accepted range against the oldest expected one.
  always @(posedge clk) begin : check_ranges
    range_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      ranges_seen++;
      if (pending_ranges.size() == 0) begin
        report_mismatch("unexpected range, start", 64'd0, 64'(out_range_start));
      end else begin
        want = pending_ranges.pop_front();
        if (out_range_start !== want.rstart)
          report_mismatch("range_start", 64'(want.rstart), 64'(out_range_start));
        if (out_range_size !== want.rsize)
          report_mismatch("range_size", 64'(want.rsize), 64'(out_range_size));
        if (out_range_index !== want.ridx)
          report_mismatch("range_index", 64'(want.ridx), 64'(out_range_index));
        if (out_ranges_total !== want.rtotal)
          report_mismatch("ranges_total", 64'(want.rtotal), 64'(out_ranges_total));
        if (out_last_range !== want.rlast)
          report_mismatch("last_range", 64'(want.rlast), 64'(out_last_range));
      end
    end
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d ranges outstanding",
               idle_cycles, pending_ranges.size());
      $display("FAIL work_range_partitioner_core");
      $finish;
    end
  end

endmodule
